[src/ffd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_pkg: shared types and constants
// Point and weight types, fixed-point widths and register indexes.
// ----------------------------------------------------------------------------
package ffd_pkg;

  localparam int COORD_W = 32;   // signed Q15.16 coordinate
  localparam int SIZE_W  = 31;   // unsigned lattice edge length
  localparam int FRAC    = 30;   // fraction bits of lattice coordinates
  localparam int NPTS    = 64;   // 4x4x4 control points
  localparam int IDX_W   = 6;
  localparam int DIV_STEPS = 30;
  localparam int ACC_W   = 64;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0]         size_t;
  typedef logic [SIZE_W-1:0]         frac_t;    // lattice coordinate, Q30
  typedef logic [COORD_W-1:0]        weight_t;  // Bernstein weight, Q30

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic start;
    logic done;
  } handshake_t;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_SIZE_X   = 3'd3;
  localparam logic [2:0] REG_SIZE_Y   = 3'd4;
  localparam logic [2:0] REG_SIZE_Z   = 3'd5;

  localparam coord_t ORIGIN_RESET = 32'hFF88_0000;  // -120.0
  localparam size_t  SIZE_RESET   = 31'h00F0_0000;  // 240.0

endpackage

[src/ffd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_cell: one control point cell of the lattice ring
// Holds one point and passes it to its neighbor every cycle.
// ----------------------------------------------------------------------------
module ffd_cell (
  input  logic            clk,
  input  ffd_pkg::point_t d,
  output ffd_pkg::point_t q
);

  always_ff @(posedge clk) begin
    q <= d;
  end

endmodule

[src/ffd_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_div: lattice coordinate divider
// Restoring divide of d * 2^30 by size, one quotient bit per cycle, d <= size.
// ----------------------------------------------------------------------------
module ffd_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ffd_pkg::size_t      d,
  input  ffd_pkg::size_t      size,
  output logic                done,
  output ffd_pkg::frac_t      q
);

  logic [4:0]                 cnt;
  logic                       busy;
  logic [ffd_pkg::SIZE_W:0]   r;
  logic [ffd_pkg::SIZE_W:0]   r2;
  logic                       ge;

  assign r2   = {r[ffd_pkg::SIZE_W-1:0], 1'b0};
  assign ge   = r2 >= {1'b0, size};
  assign done = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(ffd_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (d == size) begin
        q <= ffd_pkg::frac_t'(1);
        r <= '0;
      end else begin
        q <= '0;
        r <= {1'b0, d};
      end
    end else if (busy) begin
      q <= {q[ffd_pkg::SIZE_W-2:0], ge};
      r <= ge ? (r2 - {1'b0, size}) : r2;
    end
  end

endmodule

[src/ffd_bern.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_bern: cubic Bernstein weights for one axis
// Six truncated products through one shared multiplier.
// ----------------------------------------------------------------------------
module ffd_bern (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ffd_pkg::frac_t    s,
  output logic              done,
  output ffd_pkg::weight_t  w [4]
);

  localparam ffd_pkg::frac_t ONE = ffd_pkg::frac_t'(1) << ffd_pkg::FRAC;

  logic [2:0]           step;
  logic                 busy;
  ffd_pkg::frac_t       o, sp2, sp3, op2, op3, m1, m2;
  ffd_pkg::frac_t       a, b;
  logic [61:0]          prod;
  ffd_pkg::frac_t       p;

  assign o    = ONE - s;
  assign prod = a * b;
  assign p    = prod[60:30];
  assign done = !busy;

  always_comb begin
    case (step)
      3'd0:    begin a = s;   b = s;   end
      3'd1:    begin a = sp2; b = s;   end
      3'd2:    begin a = o;   b = o;   end
      3'd3:    begin a = op2; b = o;   end
      3'd4:    begin a = s;   b = op2; end
      3'd5:    begin a = sp2; b = o;   end
      default: begin a = '0;  b = '0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 3'd1;
      if (step == 3'd5) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      case (step)
        3'd0:    sp2 <= p;
        3'd1:    sp3 <= p;
        3'd2:    op2 <= p;
        3'd3:    op3 <= p;
        3'd4:    m1  <= p;
        3'd5:    m2  <= p;
        default: ;
      endcase
    end
  end

  assign w[0] = {1'b0, op3};
  assign w[1] = 32'({1'b0, m1}) * 32'd3;
  assign w[2] = 32'({1'b0, m2}) * 32'd3;
  assign w[3] = {1'b0, sp3};

endmodule

[src/free_form_deformation_eval_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_form_deformation_eval_top: trivariate cubic Bezier lattice deformer
// Loads 64 control points and moves vertices through the lattice.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): mode 0 writes control point
// point_index; mode 1 deforms the vertex x_in, y_in, z_in. One request is
// worked on at a time; in_stall is high while it is in progress.
// Output channel (out_valid / out_stall): one result per vertex request,
// none for a control point write. The result sits in an output register, so
// a new request is taken while a result still waits to be read.
// Control points live in a ring of 64 cells that rotates every cycle.
// - Point write: done when the target slot passes the ring head.
// - Vertex outside the lattice: passed through unchanged.
// - Vertex inside: a divider per axis, 6 multiply steps for the weights,
//   then one lattice term per cycle over the 64 ring cells, through a
//   product pipeline (stages A, B, C), accumulation and rounding.
// The ring read sets the pace: one cell reaches the head per cycle.
// Reset clears control state and loads the register defaults (origin -120.0,
// edge 240.0); control points hold no value until written.
// A stalled receiver holds the result; the next vertex waits in its
// final stage until the output register is free.
// ----------------------------------------------------------------------------
module free_form_deformation_eval_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [5:0]  point_index,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic signed [31:0] z_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic signed [31:0] z_out,
  output logic        moved,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WR    = 3'd1;
  localparam logic [2:0] S_MAP   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_BERN  = 3'd4;
  localparam logic [2:0] S_ACC   = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam int NP = ffd_pkg::NPTS;

  // Configuration registers
  ffd_pkg::coord_t origin_x, origin_y, origin_z;
  ffd_pkg::size_t  size_x, size_y, size_z;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= ffd_pkg::ORIGIN_RESET;
      origin_y <= ffd_pkg::ORIGIN_RESET;
      origin_z <= ffd_pkg::ORIGIN_RESET;
      size_x   <= ffd_pkg::SIZE_RESET;
      size_y   <= ffd_pkg::SIZE_RESET;
      size_z   <= ffd_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        ffd_pkg::REG_ORIGIN_X: origin_x <= pwdata;
        ffd_pkg::REG_ORIGIN_Y: origin_y <= pwdata;
        ffd_pkg::REG_ORIGIN_Z: origin_z <= pwdata;
        ffd_pkg::REG_SIZE_X:   size_x   <= pwdata[30:0];
        ffd_pkg::REG_SIZE_Y:   size_y   <= pwdata[30:0];
        ffd_pkg::REG_SIZE_Z:   size_z   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      ffd_pkg::REG_ORIGIN_X: prdata = origin_x;
      ffd_pkg::REG_ORIGIN_Y: prdata = origin_y;
      ffd_pkg::REG_ORIGIN_Z: prdata = origin_z;
      ffd_pkg::REG_SIZE_X:   prdata = {1'b0, size_x};
      ffd_pkg::REG_SIZE_Y:   prdata = {1'b0, size_y};
      ffd_pkg::REG_SIZE_Z:   prdata = {1'b0, size_z};
      default:               prdata = '0;
    endcase
  end

  // Request capture
  logic [2:0]       state;
  logic             in_acc;
  logic [5:0]       req_idx;
  ffd_pkg::point_t  req_pt;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_idx <= point_index;
      req_pt  <= '{x: x_in, y: y_in, z: z_in};
    end
  end

  // Control point ring: cell 0 is the head, head_idx names its point
  ffd_pkg::point_t  ring [NP];
  ffd_pkg::point_t  tail_in;
  logic [5:0]       head_idx;
  logic             wr_hit;

  assign wr_hit  = (state == S_WR) && (head_idx == req_idx);
  assign tail_in = wr_hit ? req_pt : ring[0];

  for (genvar c = 0; c < NP; c++) begin : g_ring
    if (c == NP - 1) begin : g_tail
      ffd_cell u_cell (.clk(clk), .d(tail_in), .q(ring[c]));
    end else begin : g_body
      ffd_cell u_cell (.clk(clk), .d(ring[c+1]), .q(ring[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx <= '0;
    end else begin
      head_idx <= head_idx + 6'd1;
    end
  end

  // Inside test: 0 <= coord - origin <= size on every axis
  logic signed [32:0] dx, dy, dz;
  logic               in_x, in_y, in_z, in_box;

  assign dx = {req_pt.x[31], req_pt.x} - {origin_x[31], origin_x};
  assign dy = {req_pt.y[31], req_pt.y} - {origin_y[31], origin_y};
  assign dz = {req_pt.z[31], req_pt.z} - {origin_z[31], origin_z};
  assign in_x = !dx[32] && (dx[31:0] <= {1'b0, size_x}) && (size_x != '0);
  assign in_y = !dy[32] && (dy[31:0] <= {1'b0, size_y}) && (size_y != '0);
  assign in_z = !dz[32] && (dz[31:0] <= {1'b0, size_z}) && (size_z != '0);
  assign in_box = in_x && in_y && in_z;

  // Dividers and weight units
  ffd_pkg::handshake_t hs_div [3];
  ffd_pkg::handshake_t hs_bern [3];
  ffd_pkg::frac_t      s_frac [3];
  ffd_pkg::weight_t    ws [4];
  ffd_pkg::weight_t    wt [4];
  ffd_pkg::weight_t    wu [4];
  logic                div_start, bern_start;

  assign div_start  = (state == S_MAP) && in_box;
  assign bern_start = (state == S_DIV) && hs_div[0].done && hs_div[1].done &&
                      hs_div[2].done;

  for (genvar a = 0; a < 3; a++) begin : g_hs
    assign hs_div[a].start  = div_start;
    assign hs_bern[a].start = bern_start;
  end

  ffd_div u_div_x (.clk(clk), .rst(rst), .start(hs_div[0].start),
                   .d(dx[30:0]), .size(size_x), .done(hs_div[0].done),
                   .q(s_frac[0]));
  ffd_div u_div_y (.clk(clk), .rst(rst), .start(hs_div[1].start),
                   .d(dy[30:0]), .size(size_y), .done(hs_div[1].done),
                   .q(s_frac[1]));
  ffd_div u_div_z (.clk(clk), .rst(rst), .start(hs_div[2].start),
                   .d(dz[30:0]), .size(size_z), .done(hs_div[2].done),
                   .q(s_frac[2]));

  ffd_bern u_bern_s (.clk(clk), .rst(rst), .start(hs_bern[0].start),
                     .s(s_frac[0]), .done(hs_bern[0].done), .w(ws));
  ffd_bern u_bern_t (.clk(clk), .rst(rst), .start(hs_bern[1].start),
                     .s(s_frac[1]), .done(hs_bern[1].done), .w(wt));
  ffd_bern u_bern_u (.clk(clk), .rst(rst), .start(hs_bern[2].start),
                     .s(s_frac[2]), .done(hs_bern[2].done), .w(wu));

  // Term pipeline: A = wij, B = full weight, C = products, then accumulate
  logic [5:0]         term_cnt;
  logic               issue;
  logic               pa_v, pb_v, pc_v;
  ffd_pkg::point_t    pa_cp, pb_cp;
  ffd_pkg::weight_t   pa_wij, pb_w;
  logic [1:0]         pa_k;
  logic [63:0]        prod_a, prod_b;
  logic signed [64:0] mx, my, mz;
  logic signed [63:0] pc_x, pc_y, pc_z;
  logic signed [63:0] acc_x, acc_y, acc_z;
  logic               bern_done;

  assign bern_done = hs_bern[0].done && hs_bern[1].done && hs_bern[2].done;
  assign issue  = (state == S_ACC);
  assign prod_a = ws[head_idx[5:4]] * wt[head_idx[3:2]];
  assign prod_b = pa_wij * wu[pa_k];
  assign mx = pb_cp.x * $signed({1'b0, pb_w});
  assign my = pb_cp.y * $signed({1'b0, pb_w});
  assign mz = pb_cp.z * $signed({1'b0, pb_w});

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_v <= 1'b0;
      pb_v <= 1'b0;
      pc_v <= 1'b0;
    end else begin
      pa_v <= issue;
      pb_v <= pa_v;
      pc_v <= pb_v;
    end
  end

  always_ff @(posedge clk) begin
    pa_cp  <= ring[0];
    pa_wij <= prod_a[61:30];
    pa_k   <= head_idx[1:0];
    pb_cp  <= pa_cp;
    pb_w   <= prod_b[61:30];
    pc_x   <= mx[63:0];
    pc_y   <= my[63:0];
    pc_z   <= mz[63:0];
    if (state == S_BERN) begin
      acc_x <= '0;
      acc_y <= '0;
      acc_z <= '0;
    end else if (pc_v) begin
      acc_x <= acc_x + pc_x;
      acc_y <= acc_y + pc_y;
      acc_z <= acc_z + pc_z;
    end
  end

  // Round half up at bit 30, then saturate to 32 bits
  function automatic ffd_pkg::coord_t round_sat(input logic signed [63:0] v);
    logic signed [64:0] b;
    logic signed [34:0] r;
    b = {v[63], v} + 65'sd536870912;
    r = b[64:30];
    if (r > 35'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (r < -35'sd2147483648) begin
      return 32'h8000_0000;
    end
    return r[31:0];
  endfunction

  // Result staging and output register
  ffd_pkg::point_t res_pt;
  logic            res_moved;
  logic            pipe_empty;
  logic            out_free;

  assign pipe_empty = !pa_v && !pb_v && !pc_v;
  assign out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (state == S_MAP && !in_box) begin
      res_pt    <= req_pt;
      res_moved <= 1'b0;
    end else if (state == S_DRAIN && pipe_empty) begin
      res_pt    <= '{x: round_sat(acc_x), y: round_sat(acc_y),
                     z: round_sat(acc_z)};
      res_moved <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      x_out <= res_pt.x;
      y_out <= res_pt.y;
      z_out <= res_pt.z;
      moved <= res_moved;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      term_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= mode ? S_MAP : S_WR;
          end
        end
        S_WR: begin
          if (wr_hit) begin
            state <= S_IDLE;
          end
        end
        S_MAP: begin
          state <= in_box ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (bern_start) begin
            state <= S_BERN;
          end
        end
        S_BERN: begin
          if (bern_done) begin
            state    <= S_ACC;
            term_cnt <= '0;
          end
        end
        S_ACC: begin
          term_cnt <= term_cnt + 6'd1;
          if (term_cnt == 6'(NP - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (pipe_empty) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/ffd_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_check: port-level checks for the deformation block
// Watches the handshakes and the configuration port over time.
// ----------------------------------------------------------------------------
module ffd_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic signed [31:0] x_out,
  input logic        pready
);

  // held result stays and keeps its x_out value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(x_out))
    else $error("stalled result dropped or changed");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // a taken request keeps the input side busy
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not busy after request");

  // a control point write makes no result
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !mode |=> !$rose(out_valid))
    else $error("result after point write");

  assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind free_form_deformation_eval_top ffd_check u_check (.*);
